// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

	localparam int TCW_MAX_COLS = 256;
	localparam int TCW_MAX_ROWS = 128;

	localparam int RESET_COLS = 80;
	localparam int RESET_ROWS = 25;

	localparam int CELL_W = 16;
	localparam int APB_AW = 3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [7:0] CHAR_NUL = 8'd0;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	localparam logic [1:0] SCROLL_TWICE = 2'd2;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	typedef enum logic {
		REG_COLUMNS = 1'b0,
		REG_ROWS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic wr;
		reg_idx_t idx;
		logic [31:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [1:0] n_scroll;
		logic has_write;
		logic [CELL_W-1:0] wcell;
		logic [7:0] glyph;
		logic [7:0] colour;
		logic has_cursor;
		logic [CELL_W-1:0] ccell;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

// ----- rtl/core/tcw_in_if.sv -----
interface tcw_in_if;
	logic valid;
	logic ready;
	logic [7:0] char_code;
	logic [7:0] attr;
	logic end_of_string;

	modport source (output valid, output char_code, output attr, output end_of_string,
		input ready);
	modport sink (input valid, input char_code, input attr, input end_of_string,
		output ready);
endinterface

// ----- rtl/core/tcw_out_if.sv -----
interface tcw_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [15:0] cell_res;
	logic [7:0] glyph;
	logic [7:0] colour;
	logic last;

	modport source (output valid, output kind, output cell_res, output glyph,
		output colour, output last, input ready);
	modport sink (input valid, input kind, input cell_res, input glyph,
		input colour, input last, output ready);
endinterface

// ----- rtl/core/tcw_front.sv -----
module tcw_front import tcw_pkg::*; #(
	parameter int MAX_COLS = TCW_MAX_COLS,
	parameter int MAX_ROWS = TCW_MAX_ROWS
) (
	input logic clk,
	input logic arst_n,
	tcw_in_if.sink item_in,
	input cfg_wr_t cfg,
	input reg_idx_t cfg_rd_idx,
	output logic [31:0] cfg_rdata,
	input q_status_t q_st,
	output logic push,
	output job_t job
);

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam logic [9:0] MAX_COLS_V = 10'(MAX_COLS);
	localparam logic [8:0] MAX_ROWS_V = 9'(MAX_ROWS);
	localparam logic [8:0] RST_COLS = 9'((RESET_COLS > MAX_COLS) ? MAX_COLS : RESET_COLS);
	localparam logic [7:0] RST_ROWS = 8'((RESET_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ROWS);

	logic [8:0] columns_q;
	logic [7:0] rows_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [CELL_W-1:0] cell_q;

	logic [ROW_W-1:0] row_n, row_w, rows_m1;
	logic [COL_W-1:0] col_n, col_w;
	logic [CELL_W-1:0] cell_n, wcell;
	logic [CELL_W-1:0] cols16, col16;
	logic [1:0] n_scroll;
	logic has_write;
	logic is_nl, is_nul, at_end, at_last, wrap, accept;
	logic [9:0] col_inc;
	logic [8:0] cols_sat;
	logic [7:0] rows_sat;

	assign is_nl = item_in.char_code == CHAR_NEWLINE;
	assign is_nul = item_in.char_code == CHAR_NUL;
	assign at_end = 9'(row_q) >= 9'(rows_q);
	assign at_last = 9'(row_q) == (9'(rows_q) - 9'd1);
	assign rows_m1 = ROW_W'(rows_q - 8'd1);
	assign cols16 = CELL_W'(columns_q);
	assign col16 = CELL_W'(col_q);

	always_comb begin
		row_w = row_q;
		col_w = col_q;
		wcell = cell_q;
		row_n = row_q;
		col_n = col_q;
		cell_n = cell_q;
		n_scroll = 2'd0;
		has_write = 1'b0;
		col_inc = 10'(col_q) + 10'd1;
		wrap = 1'b0;
		if (is_nl) begin
			col_n = '0;
			if (at_end) begin
				n_scroll = SCROLL_TWICE;
				row_n = rows_m1;
				cell_n = cell_q - cols16;
			end else if (at_last) begin
				n_scroll = 2'd1;
				cell_n = cell_q - col16;
			end else begin
				row_n = ROW_W'(row_q + 1'b1);
				cell_n = cell_q - col16 + cols16;
			end
		end else if (!is_nul) begin
			has_write = 1'b1;
			if (at_end) begin
				n_scroll = 2'd1;
				row_w = rows_m1;
				col_w = '0;
				wcell = cell_q - cols16;
			end
			col_inc = 10'(col_w) + 10'd1;
			wrap = col_inc >= 10'(columns_q);
			if (wrap) begin
				col_n = '0;
				row_n = ROW_W'(row_w + 1'b1);
			end else begin
				col_n = COL_W'(col_inc);
				row_n = row_w;
			end
			cell_n = wcell + 1'b1;
		end
	end

	assign item_in.ready = !q_st.full;
	assign accept = item_in.valid && !q_st.full;
	assign push = accept && (has_write || (n_scroll != 2'd0) || item_in.end_of_string);

	always_comb begin
		job.n_scroll = n_scroll;
		job.has_write = has_write;
		job.wcell = wcell;
		job.glyph = item_in.char_code;
		job.colour = item_in.attr;
		job.has_cursor = item_in.end_of_string;
		job.ccell = cell_n;
	end

	always_comb begin
		if (cfg.data[8:0] == 9'd0) begin
			cols_sat = 9'd1;
		end else if (10'(cfg.data[8:0]) > MAX_COLS_V) begin
			cols_sat = MAX_COLS_V[8:0];
		end else begin
			cols_sat = cfg.data[8:0];
		end
		if (cfg.data[7:0] == 8'd0) begin
			rows_sat = 8'd1;
		end else if (9'(cfg.data[7:0]) > MAX_ROWS_V) begin
			rows_sat = MAX_ROWS_V[7:0];
		end else begin
			rows_sat = cfg.data[7:0];
		end
	end

	always_comb begin
		unique case (cfg_rd_idx)
			REG_COLUMNS: cfg_rdata = 32'(columns_q);
			REG_ROWS: cfg_rdata = 32'(rows_q);
			default: cfg_rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= RST_COLS;
			rows_q <= RST_ROWS;
			row_q <= '0;
			col_q <= '0;
			cell_q <= '0;
		end else if (cfg.wr) begin
			unique case (cfg.idx)
				REG_COLUMNS: columns_q <= cols_sat;
				REG_ROWS: rows_q <= rows_sat;
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
			cell_q <= '0;
		end else if (accept) begin
			row_q <= row_n;
			col_q <= col_n;
			cell_q <= cell_n;
		end
	end

`ifndef SYNTHESIS
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		9'(row_q) <= 9'(rows_q))
		else $error("cursor row beyond one-past-end");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		9'(col_q) < columns_q)
		else $error("cursor column beyond row width");
	a_cell_track: assert property (@(posedge clk) disable iff (!arst_n)
		cell_q == CELL_W'(CELL_W'(row_q) * cols16 + col16))
		else $error("cursor cell out of step with row and column");
`endif

endmodule

// ----- rtl/core/tcw_queue.sv -----
module tcw_queue import tcw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t job_in,
	input logic pop,
	output job_t head,
	output q_status_t st
);

	job_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign st.empty = count_q == '0;
	assign st.full = count_q == (QPTR_W+1)'(QDEPTH);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/tcw_back.sv -----
module tcw_back import tcw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input job_t head,
	input q_status_t q_st,
	output logic pop,
	tcw_out_if.source result_out
);

	logic [1:0] step_q;
	logic [1:0] total;
	logic is_last, valid, accept;
	kind_t kind;

	assign total = head.n_scroll + 2'(head.has_write) + 2'(head.has_cursor);
	assign is_last = step_q == (total - 2'd1);
	assign valid = !q_st.empty;
	assign accept = valid && result_out.ready;
	assign pop = accept && is_last;

	always_comb begin
		if (step_q < head.n_scroll) begin
			kind = KIND_SCROLL;
		end else if (step_q == head.n_scroll && head.has_write) begin
			kind = KIND_WRITE;
		end else begin
			kind = KIND_CURSOR;
		end
	end

	always_comb begin
		result_out.valid = valid;
		result_out.kind = kind;
		result_out.last = is_last;
		result_out.cell_res = '0;
		result_out.glyph = '0;
		result_out.colour = '0;
		unique case (kind)
			KIND_WRITE: begin
				result_out.cell_res = head.wcell;
				result_out.glyph = head.glyph;
				result_out.colour = head.colour;
			end
			KIND_CURSOR: result_out.cell_res = head.ccell;
			KIND_SCROLL: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (accept) begin
			step_q <= is_last ? 2'd0 : step_q + 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_step_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> step_q < total)
		else $error("result step past end of item");
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> step_q == 2'd0)
		else $error("result step left over with empty queue");
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_last |=> step_q == $past(step_q) + 2'd1 && valid)
		else $error("result step failed to advance within item");
`endif

endmodule

// ----- rtl/core/text_console_writer_unit.sv -----
// Text console writer: takes one character and colour attribute per item and turns
// it into cell writes, scroll-up commands and, on the last item of a string, a
// cursor position, tracking the cursor on a screen whose width and height are set
// through the APB registers (columns at 0x0, rows at 0x4; any write homes the
// cursor). The front accepts one item per cycle while the queue is not full and
// works out its results at once; the back emits one result per cycle while the
// receiver is ready, from a four-deep queue. An item gives one to three results;
// without stalls, items with one result flow at one per cycle. A zero byte, or a
// newline that needs no scroll, without end of string gives no result at all.
module text_console_writer_unit import tcw_pkg::*; #(
	parameter int MAX_COLS = TCW_MAX_COLS,
	parameter int MAX_ROWS = TCW_MAX_ROWS
) (
	input logic clk,
	input logic arst_n,
	tcw_in_if.sink item_in,
	tcw_out_if.source result_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_wr_t cfg;
	reg_idx_t rd_idx;
	q_status_t q_st;
	job_t job, head;
	logic push, pop;

	assign pready = 1'b1;
	assign rd_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		cfg.wr = psel && penable && pwrite;
		cfg.idx = rd_idx;
		cfg.data = pwdata;
	end

	tcw_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_in),
		.cfg(cfg),
		.cfg_rd_idx(rd_idx),
		.cfg_rdata(prdata),
		.q_st(q_st),
		.push(push),
		.job(job)
	);

	tcw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.job_in(job),
		.pop(pop),
		.head(head),
		.st(q_st)
	);

	tcw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_st(q_st),
		.pop(pop),
		.result_out(result_out)
	);

endmodule

// ----- verif/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int LIMIT = 200000;
	localparam int SETTLE = 12;
	localparam int N_DIR = 24;
	localparam int N_PHASE = 8;

	typedef enum logic {
		ROW_CHAR,
		ROW_REG
	} row_op_t;

	typedef struct {
		row_op_t op;
		reg_idx_t idx;
		logic [31:0] val;
		logic [7:0] ch;
		logic [7:0] at;
		logic eos;
		bit pin;
		kind_t pk;
		logic [15:0] pc;
	} stim_row_t;

	typedef struct {
		kind_t kind;
		logic [15:0] cell_idx;
		logic [7:0] glyph;
		logic [7:0] colour;
		logic last;
	} console_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;

	tcw_in_if in_b ();
	tcw_out_if res_b ();

	text_console_writer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(in_b),
		.result_out(res_b),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	int scr_cols, scr_rows;
	int cur_row, cur_col;
	logic [15:0] cur_cell;
	console_op_t pending_ops[$];

	int mismatches = 0;
	int cycle_cnt = 0;
	int rx_hold = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	function automatic void push_op(kind_t k, logic [15:0] c, logic [7:0] g, logic [7:0] a);
		console_op_t op;
		op.kind = k;
		op.cell_idx = c;
		op.glyph = g;
		op.colour = a;
		op.last = 1'b0;
		pending_ops.push_back(op);
	endfunction

	function automatic void apply_geometry(reg_idx_t idx, logic [31:0] v);
		int n;
		if (idx == REG_COLUMNS) begin
			n = int'(v[8:0]);
			scr_cols = (n < 1) ? 1 : (n > TCW_MAX_COLS) ? TCW_MAX_COLS : n;
		end else begin
			n = int'(v[7:0]);
			scr_rows = (n < 1) ? 1 : (n > TCW_MAX_ROWS) ? TCW_MAX_ROWS : n;
		end
		cur_row = 0;
		cur_col = 0;
		cur_cell = '0;
	endfunction

	function automatic void predict_console_ops(logic [7:0] ch, logic [7:0] at, logic eos);
		int n0;
		n0 = pending_ops.size();
		if (ch == CHAR_NEWLINE) begin
			cur_row++;
			cur_col = 0;
			while (cur_row >= scr_rows) begin
				push_op(KIND_SCROLL, '0, '0, '0);
				cur_row--;
			end
			cur_cell = 16'(cur_row * scr_cols + cur_col);
		end else if (ch != CHAR_NUL) begin
			if (cur_row >= scr_rows) begin
				push_op(KIND_SCROLL, '0, '0, '0);
				cur_row = scr_rows - 1;
				cur_col = 0;
				cur_cell = 16'(cur_row * scr_cols);
			end
			push_op(KIND_WRITE, cur_cell, ch, at);
			cur_col++;
			if (cur_col >= scr_cols) begin
				cur_col = 0;
				cur_row++;
			end
			cur_cell = 16'(cur_row * scr_cols + cur_col);
		end
		if (eos)
			push_op(KIND_CURSOR, cur_cell, '0, '0);
		if (pending_ops.size() > n0)
			pending_ops[pending_ops.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t: MISMATCH %s", $realtime, msg);
		mismatches++;
	endtask

	// entered and left at a falling edge; valid stays high after acceptance
	task automatic send_char(logic [7:0] ch, logic [7:0] at, logic eos, bit pin, kind_t pk,
			logic [15:0] pc);
		int gap;
		int n0;
		gap = tx_burst ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			in_b.valid <= 1'b0;
			@(negedge clk);
		end
		n0 = pending_ops.size();
		predict_console_ops(ch, at, eos);
		if (pin && pending_ops.size() > n0) begin
			pending_ops[n0].kind = pk;
			pending_ops[n0].cell_idx = pc;
		end
		in_b.valid <= 1'b1;
		in_b.char_code <= ch;
		in_b.attr <= at;
		in_b.end_of_string <= eos;
		do @(posedge clk); while (!in_b.ready);
		@(negedge clk);
	endtask

	task automatic drain;
		in_b.valid <= 1'b0;
		while (pending_ops.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_geometry(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// receiver: hold ready low for a drawn number of cycles after each item
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			res_b.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			res_b.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		console_op_t exp_op;
		cycle_cnt++;
		if (arst_n && res_b.valid && res_b.ready) begin
			rx_hold = rx_burst ? 0 : $urandom_range(0, 5);
			if (pending_ops.size() == 0) begin
				report_mismatch($sformatf("unexpected item kind=%0d cell=%0d glyph=%0d",
					res_b.kind, res_b.cell_res, res_b.glyph));
			end else begin
				exp_op = pending_ops.pop_front();
				if (res_b.kind !== exp_op.kind || res_b.cell_res !== exp_op.cell_idx
						|| res_b.glyph !== exp_op.glyph || res_b.colour !== exp_op.colour
						|| res_b.last !== exp_op.last)
					report_mismatch($sformatf(
						"got k=%0d c=%0d g=%0d a=%0d l=%0d exp k=%0d c=%0d g=%0d a=%0d l=%0d",
						res_b.kind, res_b.cell_res, res_b.glyph, res_b.colour, res_b.last,
						exp_op.kind, exp_op.cell_idx, exp_op.glyph, exp_op.colour,
						exp_op.last));
			end
		end
	end

	initial begin
		wait (cycle_cnt >= LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	stim_row_t dir_tbl [N_DIR] = '{
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h41, 8'h07, 1'b0, 1'b1, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'hFF, 8'hFF, 1'b1, 1'b1, KIND_WRITE, 16'd1},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h00, 8'h55, 1'b1, 1'b1, KIND_CURSOR, 16'd2},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h0A, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h0A, 8'h1F, 1'b1, 1'b1, KIND_CURSOR, 16'd160},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h01, 8'h80, 1'b0, 1'b1, KIND_WRITE, 16'd160},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h7F, 8'h00, 1'b1, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_REG, REG_COLUMNS, 32'd1, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_REG, REG_ROWS, 32'd1, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h78, 8'h0F, 1'b0, 1'b1, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h79, 8'hF0, 1'b1, 1'b1, KIND_SCROLL, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h0A, 8'hAA, 1'b1, 1'b1, KIND_SCROLL, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h0A, 8'h00, 1'b0, 1'b1, KIND_SCROLL, 16'd0},
		'{ROW_REG, REG_COLUMNS, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_REG, REG_ROWS, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h80, 8'h01, 1'b1, 1'b1, KIND_WRITE, 16'd0},
		'{ROW_REG, REG_COLUMNS, 32'd511, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_REG, REG_ROWS, 32'd255, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h20, 8'h07, 1'b0, 1'b1, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h0A, 8'h00, 1'b1, 1'b1, KIND_CURSOR, 16'd256},
		'{ROW_REG, REG_COLUMNS, 32'hFFFF_FE03, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_REG, REG_ROWS, 32'h0000_0102, 8'h00, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0},
		'{ROW_CHAR, REG_COLUMNS, 32'd0, 8'h41, 8'h00, 1'b0, 1'b0, KIND_WRITE, 16'd0}
	};

	int ph_cols [N_PHASE] = '{256, 1, 0, 300, 5, -1, 2, 80};
	int ph_rows [N_PHASE] = '{128, 1, 0, 200, 3, -1, 128, 25};
	int ph_nl [N_PHASE] = '{90, 15, 15, 10, 20, 20, 5, 15};
	int ph_len [N_PHASE] = '{150, 30, 30, 30, 30, 30, 30, 30};

	initial begin
		logic [31:0] cv, rv;
		logic [7:0] ch;
		logic eos;
		int str_left, r;
		in_b.valid = 1'b0;
		in_b.char_code = '0;
		in_b.attr = '0;
		in_b.end_of_string = 1'b0;
		res_b.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		scr_cols = RESET_COLS;
		scr_rows = RESET_ROWS;
		cur_row = 0;
		cur_col = 0;
		cur_cell = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].op == ROW_REG)
				write_reg(dir_tbl[i].idx, dir_tbl[i].val);
			else
				send_char(dir_tbl[i].ch, dir_tbl[i].at, dir_tbl[i].eos, dir_tbl[i].pin,
					dir_tbl[i].pk, dir_tbl[i].pc);
		end

		for (int p = 0; p < N_PHASE; p++) begin
			cv = (ph_cols[p] < 0) ? $urandom_range(1, 12) : ph_cols[p];
			rv = (ph_rows[p] < 0) ? $urandom_range(1, 6) : ph_rows[p];
			if ($urandom_range(0, 1)) begin
				write_reg(REG_COLUMNS, cv);
				write_reg(REG_ROWS, rv);
			end else begin
				write_reg(REG_ROWS, rv);
				write_reg(REG_COLUMNS, cv);
			end
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			str_left = 0;
			for (int k = 0; k < ph_len[p]; k++) begin
				if (str_left == 0)
					str_left = $urandom_range(1, 8);
				r = $urandom_range(0, 99);
				if (r < ph_nl[p])
					ch = CHAR_NEWLINE;
				else if (r < ph_nl[p] + 6)
					ch = CHAR_NUL;
				else
					ch = 8'($urandom_range(1, 255));
				str_left--;
				eos = (str_left == 0) || ($urandom_range(0, 19) == 0);
				send_char(ch, 8'($urandom), eos, 1'b0, KIND_WRITE, '0);
			end
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		drain();
		repeat (20) @(negedge clk);

		if (mismatches == 0 && pending_ops.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_in_if.sv
rtl/core/tcw_out_if.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer_unit.sv
verif/tb.sv
